@@ rtl/lzw_pkg.sv @@
// Package: sizes, dictionary entry layout and sequencer states for the LZW encoder.
package lzw_pkg;
    localparam int CODE_W       = 12;
    localparam int DICT_ENTRIES = 4096;
    localparam int FIRST_CODE   = 256;
    localparam int NFC_W        = 13;
    localparam int LEN_W        = 4;
    localparam int MAX_STR_LEN  = 9;
    localparam int DICT_DEPTH   = DICT_ENTRIES - FIRST_CODE;
    localparam int DICT_AW      = $clog2(DICT_DEPTH);
    localparam int SLOT_W       = 12;
    localparam int SLOTS        = 1 << SLOT_W;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [CODE_W-1:0] pfx;
        logic [7:0]        dbyte;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_DICT,
        S_MISS,
        S_EOM
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_hash(input logic [CODE_W-1:0] pfx,
                                                    input logic [7:0] b);
        slot_hash = pfx ^ {b, 4'h0} ^ {4'h0, b};
    endfunction
endpackage

@@ rtl/lzw_if.sv @@
// Handshake channels: message bytes in, LZW codes out.
interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface lzw_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] code;
    logic        last_code;
    modport source (output valid, output code, output last_code, input ready);
    modport sink (input valid, input code, input last_code, output ready);
endinterface

@@ rtl/lzw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/lzw_byte_encoder.sv @@
// Top level: LZW byte encoder with hashed slot table and code-indexed dictionary.
//
//  channel  dir  fields                       word
//  i_in     in   data_byte[7:0], end_of_message  one message byte
//  o_out    out  code[11:0], last_code            one LZW code
//
// The first byte of a message passes S_EOM only, a byte over the string cap S_MISS and
// S_EOM. A looked-up byte reads its slot in S_TAB: a free slot means a miss, a live code
// is checked in S_DICT against its entry (hit, or miss on a stale slot); a slot holding
// another string sends it back to S_TAB for the next slot, in linear probing.
// No clearing pass: a slot counts only if its code is below the next free code and
// the dictionary entry of that code points back to the slot.
// Reset is synchronous; a stalled output holds the sequencer in its emit state.
module lzw_byte_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzw_in_if.sink      i_in,
    lzw_out_if.source   o_out
);
    lzw_pkg::t_state r_state, n_state;

    logic [lzw_pkg::CODE_W-1:0] r_prefix, n_prefix;
    logic [lzw_pkg::LEN_W-1:0]  r_len, n_len;
    logic                       r_have, n_have;
    logic [lzw_pkg::NFC_W-1:0]  r_nfc, n_nfc;
    logic [7:0]                 r_byte, n_byte;
    logic                       r_eom, n_eom;
    logic [lzw_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [lzw_pkg::CODE_W-1:0] r_cand, n_cand;
    logic                       r_ovalid, n_ovalid;
    logic [lzw_pkg::CODE_W-1:0] r_ocode, n_ocode;
    logic                       r_olast, n_olast;

    logic                       tab_we;
    logic [lzw_pkg::SLOT_W-1:0] tab_waddr, tab_raddr;
    logic [lzw_pkg::CODE_W-1:0] tab_wdata, tab_rdata;
    logic                       dict_we;
    logic [lzw_pkg::DICT_AW-1:0] dict_waddr, dict_raddr;
    lzw_pkg::t_entry            dict_wdata, dict_rdata;

    logic out_free, insert_ok;
    logic [lzw_pkg::NFC_W-1:0] cand_ext, nfc_base;

    lzw_ram #(.WIDTH(lzw_pkg::CODE_W), .DEPTH(lzw_pkg::SLOTS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr(tab_raddr), .o_rdata(tab_rdata)
    );

    lzw_ram #(.WIDTH(lzw_pkg::ENTRY_W), .DEPTH(lzw_pkg::DICT_DEPTH)) u_dict (
        .i_clk(i_clk), .i_we(dict_we), .i_waddr(dict_waddr), .i_wdata(dict_wdata),
        .i_raddr(dict_raddr), .o_rdata(dict_rdata)
    );

    assign out_free    = !r_ovalid || o_out.ready;
    assign insert_ok   = r_nfc < lzw_pkg::NFC_W'(lzw_pkg::DICT_ENTRIES);
    assign cand_ext    = {1'b0, tab_rdata};
    assign nfc_base    = r_nfc - lzw_pkg::NFC_W'(lzw_pkg::FIRST_CODE);

    assign i_in.ready      = (r_state == lzw_pkg::S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.code      = r_ocode;
    assign o_out.last_code = r_olast;

    always_comb begin
        n_state  = r_state;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_have   = r_have;
        n_nfc    = r_nfc;
        n_byte   = r_byte;
        n_eom    = r_eom;
        n_slot   = r_slot;
        n_cand   = r_cand;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ocode  = r_ocode;
        n_olast  = r_olast;

        tab_we     = 1'b0;
        tab_waddr  = r_slot;
        tab_wdata  = r_nfc[lzw_pkg::CODE_W-1:0];
        tab_raddr  = lzw_pkg::slot_hash(r_prefix, i_in.data_byte);
        dict_we    = 1'b0;
        dict_waddr = nfc_base[lzw_pkg::DICT_AW-1:0];
        dict_wdata = '{slot: r_slot, pfx: r_prefix, dbyte: r_byte};
        dict_raddr = (tab_rdata - lzw_pkg::CODE_W'(lzw_pkg::FIRST_CODE));

        case (r_state)
            lzw_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_byte = i_in.data_byte;
                    n_eom  = i_in.end_of_message;
                    n_slot = tab_raddr;
                    if (!r_have) begin
                        n_prefix = {4'h0, i_in.data_byte};
                        n_len    = lzw_pkg::LEN_W'(1);
                        n_have   = 1'b1;
                        n_state  = lzw_pkg::S_EOM;
                    end else if (r_len >= lzw_pkg::LEN_W'(lzw_pkg::MAX_STR_LEN)) begin
                        n_state = lzw_pkg::S_MISS;  // too long to be stored: plain miss
                    end else begin
                        n_state = lzw_pkg::S_TAB;
                    end
                end
            end
            lzw_pkg::S_TAB: begin
                n_cand = tab_rdata;
                if (cand_ext >= lzw_pkg::NFC_W'(lzw_pkg::FIRST_CODE) && cand_ext < r_nfc) begin
                    n_state = lzw_pkg::S_DICT;
                end else begin
                    // free slot: string absent, claim it while the dictionary has room
                    if (insert_ok) begin
                        tab_we  = 1'b1;
                        dict_we = 1'b1;
                        n_nfc   = r_nfc + 1'b1;
                    end
                    n_state = lzw_pkg::S_MISS;
                end
            end
            lzw_pkg::S_DICT: begin
                tab_raddr = r_slot + 1'b1;
                if (dict_rdata.slot != r_slot) begin
                    // stale slot from an earlier message
                    if (insert_ok) begin
                        tab_we  = 1'b1;
                        dict_we = 1'b1;
                        n_nfc   = r_nfc + 1'b1;
                    end
                    n_state = lzw_pkg::S_MISS;
                end else if (dict_rdata.pfx == r_prefix && dict_rdata.dbyte == r_byte) begin
                    n_prefix = r_cand;
                    n_len    = r_len + 1'b1;
                    n_state  = lzw_pkg::S_EOM;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = lzw_pkg::S_TAB;
                end
            end
            lzw_pkg::S_MISS: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = r_prefix;
                    n_olast  = 1'b0;
                    n_prefix = {4'h0, r_byte};
                    n_len    = lzw_pkg::LEN_W'(1);
                    n_state  = lzw_pkg::S_EOM;
                end
            end
            lzw_pkg::S_EOM: begin
                if (!r_eom) begin
                    n_state = lzw_pkg::S_IDLE;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ocode  = r_prefix;
                    n_olast  = 1'b1;
                    n_have   = 1'b0;
                    n_prefix = '0;
                    n_len    = '0;
                    n_nfc    = lzw_pkg::NFC_W'(lzw_pkg::FIRST_CODE);
                    n_state  = lzw_pkg::S_IDLE;
                end
            end
            default: n_state = lzw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzw_pkg::S_IDLE;
            r_prefix <= '0;
            r_len    <= '0;
            r_have   <= 1'b0;
            r_nfc    <= lzw_pkg::NFC_W'(lzw_pkg::FIRST_CODE);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_have   <= n_have;
            r_nfc    <= n_nfc;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_eom   <= n_eom;
        r_slot  <= n_slot;
        r_cand  <= n_cand;
        r_ocode <= n_ocode;
        r_olast <= n_olast;
    end
endmodule

@@ sim/lzw_byte_encoder_test.sv @@
// Self-checking test of the LZW byte encoder: predicted codes against the code channel.
module lzw_byte_encoder_test;
    typedef struct packed {
        logic [lzw_pkg::CODE_W-1:0] code;
        logic                       last_code;
    } t_code_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lzw_in_if  in_ch ();
    lzw_out_if out_ch ();

    lzw_byte_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic [lzw_pkg::CODE_W-1:0] pred_prefix;
    int unsigned       pred_len;
    logic              pred_open;
    int unsigned       pred_next_code;
    logic [19:0]       pred_dict [lzw_pkg::FIRST_CODE:lzw_pkg::DICT_ENTRIES-1];

    t_code_word expected_codes [$];
    int  n_errors = 0;
    int  idle_pct = 8;
    bit  hold_off = 1'b0;
    int  quiet_cycles = 0;

    function automatic int unsigned dict_find(logic [lzw_pkg::CODE_W-1:0] pfx, logic [7:0] b);
        for (int unsigned c = lzw_pkg::FIRST_CODE; c < pred_next_code; c++)
            if (pred_dict[c] == {pfx, b})
                return c;
        return 0;
    endfunction

    task automatic predict_codes(input logic [7:0] b, input logic eom);
        int unsigned hit;
        bit fits;
        hit = 0;
        if (!pred_open) begin
            pred_prefix = {4'h0, b};
            pred_len = 1;
            pred_open = 1'b1;
        end else begin
            fits = (pred_len + 1) <= lzw_pkg::MAX_STR_LEN;
            if (fits)
                hit = dict_find(pred_prefix, b);
            if (hit != 0) begin
                pred_prefix = hit[lzw_pkg::CODE_W-1:0];
                pred_len++;
            end else begin
                expected_codes.push_back('{pred_prefix, 1'b0});
                if (fits && pred_next_code < lzw_pkg::DICT_ENTRIES) begin
                    pred_dict[pred_next_code] = {pred_prefix, b};
                    pred_next_code++;
                end
                pred_prefix = {4'h0, b};
                pred_len = 1;
            end
        end
        if (eom) begin
            expected_codes.push_back('{pred_prefix, 1'b1});
            pred_open = 1'b0;
            pred_prefix = '0;
            pred_len = 0;
            pred_next_code = lzw_pkg::FIRST_CODE;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_codes(b, eom);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_codes.size() == 0) begin
                $display("%0t: unexpected code %0d last %0b", $time,
                         out_ch.code, out_ch.last_code);
                n_errors++;
            end else begin
                t_code_word e;
                e = expected_codes.pop_front();
                if (out_ch.code !== e.code || out_ch.last_code !== e.last_code) begin
                    $display("%0t: expected code %0d last %0b, got code %0d last %0b",
                             $time, e.code, e.last_code, out_ch.code, out_ch.last_code);
                    n_errors++;
                end
            end
        end
        out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_message(input int len, input int alpha);
        for (int i = 0; i < len; i++)
            send_byte(alpha == 256 ? 8'($urandom) : 8'($urandom_range(alpha - 1)),
                      i == len - 1);
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);            // single-byte message
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);            // zero bytes as data
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // long run of one byte; its strings stay shorter than the string cap
        for (int i = 0; i < 18; i++)
            send_byte(8'hAA, i == 17);
    endtask

    task automatic test_random_messages();
        for (int m = 0; m < 20; m++)
            send_message($urandom_range(1, 16), ($urandom_range(1) != 0) ? 3 : 256);
    endtask

    task automatic test_long_stall();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_message(40, 2);
                wait_drained();            // sender pauses until all codes are out
            end
        join
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        send_message(200, 4);
        idle_pct = 8;
    endtask

    task automatic test_long_message();
        // a long message of random bytes loads the slot table
        send_message(300, 256);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        pred_open = 1'b0;
        pred_prefix = '0;
        pred_len = 0;
        pred_next_code = lzw_pkg::FIRST_CODE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_messages();
        test_long_stall();
        test_no_idle();
        test_random_messages();
        test_long_message();
        wait_drained();
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/lzw_pkg.sv
rtl/lzw_if.sv
rtl/lzw_ram.sv
rtl/lzw_byte_encoder.sv
sim/lzw_byte_encoder_test.sv
